// ===== rtl/egr_pkg.sv =====
// egr_pkg: shared types, codes and helpers of the exp-golomb rbsp reader
// used by egr_front, egr_exec, egr_value and exp_golomb_rbsp_reader_core
// no dependencies
package egr_pkg;

  localparam int WIN_BITS  = 64;
  localparam int CODE_BITS = 32;
  localparam int Q_DEPTH   = 2;

  localparam logic [2:0] MODE_PUSH    = 3'd0;
  localparam logic [2:0] MODE_FIXED   = 3'd1;
  localparam logic [2:0] MODE_UE      = 3'd2;
  localparam logic [2:0] MODE_SE      = 3'd3;
  localparam logic [2:0] MODE_ALIGN   = 3'd4;
  localparam logic [2:0] MODE_RESTART = 3'd5;

  localparam logic [7:0] EPB_BYTE = 8'h03;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_FIXED,
    OP_UE,
    OP_SE,
    OP_ALIGN,
    OP_RESTART,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    op_t                 op;
    status_t             status;
    logic [5:0]          count;
    logic [4:0]          lz;
    logic                removed;
    logic [15:0]         removed_total;
    logic [7:0]          bits_available;
    logic [WIN_BITS-1:0] window;
  } stage_t;

  // leading zeros of a 32-bit field, 32 when all zero
  function automatic logic [5:0] clz32(input logic [CODE_BITS-1:0] x);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < CODE_BITS; i++) begin
      if (x[i]) begin
        n = 6'(CODE_BITS - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/egr_front.sv =====
// egr_front: accepts command words, classifies them and queues them
// depends on egr_pkg
module egr_front #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  logic [2:0]    mode,
  input  logic [7:0]    byte_value,
  input  logic [5:0]    bit_count,
  output logic          q_valid,
  output egr_pkg::cmd_t q_cmd,
  input  logic          pop
);

  localparam int QAW = $clog2(egr_pkg::Q_DEPTH);

  egr_pkg::cmd_t entries [egr_pkg::Q_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;
  egr_pkg::cmd_t  decoded;
  logic           push;

  always_comb begin
    unique case (mode)
      egr_pkg::MODE_PUSH:    decoded.op = egr_pkg::OP_PUSH;
      egr_pkg::MODE_FIXED:   decoded.op = egr_pkg::OP_FIXED;
      egr_pkg::MODE_UE:      decoded.op = egr_pkg::OP_UE;
      egr_pkg::MODE_SE:      decoded.op = egr_pkg::OP_SE;
      egr_pkg::MODE_ALIGN:   decoded.op = egr_pkg::OP_ALIGN;
      egr_pkg::MODE_RESTART: decoded.op = egr_pkg::OP_RESTART;
      default:               decoded.op = egr_pkg::OP_NOP;
    endcase
    decoded.byte_value = byte_value;
    // wide field reads saturate
    if (bit_count > 6'(MAX_FIELD_BITS)) begin
      decoded.count = 6'(MAX_FIELD_BITS);
    end else begin
      decoded.count = bit_count;
    end
  end

  assign cmd_stall = (fill == (QAW+1)'(egr_pkg::Q_DEPTH));
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (fill != '0);
  assign q_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/egr_exec.sv =====
// egr_exec: bit buffer, read pointer and unit state; runs one command per cycle
// while its output is taken; depends on egr_pkg
module egr_exec #(
  parameter int BUFFER_BYTES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  egr_pkg::cmd_t   cmd,
  output logic            pop,
  input  logic            a_take,
  output logic            a_valid,
  output egr_pkg::stage_t a
);

  localparam int CAP_BITS = BUFFER_BYTES * 8;
  localparam int PW = $clog2(CAP_BITS);
  localparam int FW = $clog2(CAP_BITS + 1);
  localparam int BW = $clog2(BUFFER_BYTES);
  localparam int WB = egr_pkg::WIN_BITS;

  logic [7:0]    bit_store [BUFFER_BYTES];
  logic [PW-1:0] read_pointer;
  logic [FW-1:0] fill_level;
  logic [15:0]   recent_raw_bytes;
  logic [1:0]    raw_byte_index;
  logic [15:0]   removed_count;

  logic [PW-1:0] read_pointer_next;
  logic [FW-1:0] fill_level_next;
  logic [15:0]   recent_raw_bytes_next;
  logic [1:0]    raw_byte_index_next;
  logic [15:0]   removed_count_next;

  logic [CAP_BITS-1:0] lin;
  logic [WB-1:0]       window;
  logic [5:0]          lz;
  logic [FW:0]         fill_w;
  logic [5:0]          consume;
  egr_pkg::status_t    status;
  logic                removed;
  logic                wr_en;
  logic [FW:0]         wr_pos;
  logic [BW-1:0]       wr_byte;
  logic [PW:0]         rp_sum;
  logic [2:0]          skip;
  logic                issue;

  assign issue  = q_valid && (!a_valid || a_take);
  assign pop    = issue;
  assign fill_w = {1'b0, fill_level};

  always_comb begin
    for (int b = 0; b < BUFFER_BYTES; b++) begin
      for (int j = 0; j < 8; j++) begin
        lin[b*8 + j] = bit_store[b][7-j];
      end
    end
  end

  // window of upcoming bits, first bit at the msb, zero past the fill level
  always_comb begin
    logic [PW:0] idx;
    for (int k = 0; k < WB; k++) begin
      idx = {1'b0, read_pointer} + (PW+1)'(k);
      if (idx >= (PW+1)'(CAP_BITS)) begin
        idx = idx - (PW+1)'(CAP_BITS);
      end
      window[WB-1-k] = lin[idx[PW-1:0]] && (32'(k) < 32'(fill_level));
    end
  end

  assign lz = egr_pkg::clz32(window[WB-1 -: egr_pkg::CODE_BITS]);

  always_comb begin
    status                = egr_pkg::ST_OK;
    removed               = 1'b0;
    wr_en                 = 1'b0;
    consume               = '0;
    skip                  = '0;
    recent_raw_bytes_next = recent_raw_bytes;
    raw_byte_index_next   = raw_byte_index;
    removed_count_next    = removed_count;
    unique case (cmd.op)
      egr_pkg::OP_PUSH: begin
        if (raw_byte_index == 2'd3 && recent_raw_bytes == 16'h0000 &&
            cmd.byte_value == egr_pkg::EPB_BYTE) begin
          removed = 1'b1;
          if (removed_count != 16'hFFFF) begin
            removed_count_next = removed_count + 16'd1;
          end
        end else if (fill_w + (FW+1)'(8) > (FW+1)'(CAP_BITS)) begin
          status = egr_pkg::ST_FULL;
        end else begin
          wr_en = 1'b1;
        end
        if (status == egr_pkg::ST_OK) begin
          recent_raw_bytes_next = {recent_raw_bytes[7:0], cmd.byte_value};
          if (raw_byte_index != 2'd3) begin
            raw_byte_index_next = raw_byte_index + 2'd1;
          end
        end
      end
      egr_pkg::OP_FIXED: begin
        if (32'(cmd.count) > 32'(fill_level)) begin
          status = egr_pkg::ST_SHORT;
        end else begin
          consume = cmd.count;
        end
      end
      egr_pkg::OP_UE, egr_pkg::OP_SE: begin
        if (lz == 6'd32 && 32'(fill_level) >= 32'd32) begin
          status = egr_pkg::ST_LONG;
        end else if (32'(lz) >= 32'(fill_level)) begin
          status = egr_pkg::ST_SHORT;
        end else if (32'({lz[4:0], 1'b1}) > 32'(fill_level)) begin
          status = egr_pkg::ST_SHORT;
        end else begin
          consume = {lz[4:0], 1'b1};
        end
      end
      egr_pkg::OP_ALIGN: begin
        skip = 3'(4'd8 - {1'b0, read_pointer[2:0]});
        if (32'(skip) > 32'(fill_level)) begin
          skip = fill_level[2:0];
        end
        consume = {3'b000, skip};
      end
      egr_pkg::OP_RESTART: begin
        recent_raw_bytes_next = '0;
        raw_byte_index_next   = '0;
        removed_count_next    = '0;
      end
      egr_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rp_sum = {1'b0, read_pointer} + (PW+1)'(consume);
    if (rp_sum >= (PW+1)'(CAP_BITS)) begin
      rp_sum = rp_sum - (PW+1)'(CAP_BITS);
    end
    wr_pos = (FW+1)'(read_pointer) + fill_w;
    if (wr_pos >= (FW+1)'(CAP_BITS)) begin
      wr_pos = wr_pos - (FW+1)'(CAP_BITS);
    end
    wr_byte = BW'(wr_pos >> 3);
    if (cmd.op == egr_pkg::OP_RESTART) begin
      read_pointer_next = '0;
      fill_level_next   = '0;
    end else if (wr_en) begin
      read_pointer_next = read_pointer;
      fill_level_next   = fill_level + FW'(8);
    end else begin
      read_pointer_next = rp_sum[PW-1:0];
      fill_level_next   = fill_level - FW'(consume);
    end
  end

  always_ff @(posedge clk) begin
    if (issue && wr_en) begin
      bit_store[wr_byte] <= cmd.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a.op             <= cmd.op;
      a.status         <= status;
      a.count          <= cmd.count;
      a.lz             <= lz[4:0];
      a.removed        <= removed;
      a.removed_total  <= removed_count_next;
      a.bits_available <= 8'(fill_level_next);
      a.window         <= window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer     <= '0;
      fill_level       <= '0;
      recent_raw_bytes <= '0;
      raw_byte_index   <= '0;
      removed_count    <= '0;
      a_valid          <= 1'b0;
    end else begin
      if (issue) begin
        read_pointer     <= read_pointer_next;
        fill_level       <= fill_level_next;
        recent_raw_bytes <= recent_raw_bytes_next;
        raw_byte_index   <= raw_byte_index_next;
        removed_count    <= removed_count_next;
        a_valid          <= 1'b1;
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    32'(fill_level) <= 32'(CAP_BITS))
    else $error("fill level above buffer size");

  assert property (@(posedge clk) disable iff (rst)
    32'(read_pointer) < 32'(CAP_BITS))
    else $error("read pointer outside buffer");

  assert property (@(posedge clk) disable iff (rst)
    issue && cmd.op == egr_pkg::OP_RESTART |=> fill_level == '0 && removed_count == '0)
    else $error("restart left state behind");

endmodule

// ===== rtl/egr_value.sv =====
// egr_value: forms decoded values from the captured bit window and holds the result word
// depends on egr_pkg
module egr_value (
  input  logic               clk,
  input  logic               rst,
  input  logic               a_valid,
  input  egr_pkg::stage_t    a,
  output logic               a_take,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         status,
  output logic signed [32:0] value,
  output logic               byte_removed,
  output logic [15:0]        removed_total,
  output logic [7:0]         bits_available
);

  localparam int WB = egr_pkg::WIN_BITS;

  logic [WB-1:0] fixed_bits;
  logic [WB-1:0] code;
  logic [WB-1:0] half;
  logic [32:0]   val;

  assign a_take = a_valid && (!res_valid || !res_stall);

  // code is the leading one plus the info bits, i.e. codenum + 1
  always_comb begin
    fixed_bits = a.window >> (7'd64 - {1'b0, a.count});
    code       = (a.window << a.lz) >> (6'd63 - {1'b0, a.lz});
    half       = code >> 1;
    val        = '0;
    if (a.status == egr_pkg::ST_OK) begin
      unique case (a.op)
        egr_pkg::OP_FIXED: begin
          if (a.count != '0) begin
            val = 33'(fixed_bits);
          end
        end
        egr_pkg::OP_UE: val = 33'(code) - 33'd1;
        egr_pkg::OP_SE: begin
          if (code[0]) begin
            val = 33'd0 - 33'(half);
          end else begin
            val = 33'(half);
          end
        end
        default: val = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      status         <= a.status;
      value          <= val;
      byte_removed   <= a.removed;
      removed_total  <= a.removed_total;
      bits_available <= a.bits_available;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (a_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/exp_golomb_rbsp_reader_core.sv =====
// exp_golomb_rbsp_reader_core: exp-golomb rbsp reader top level
// depends on egr_pkg, egr_front, egr_exec, egr_value
//
// command channel (cmd_valid/cmd_stall): one word per command; mode selects
// push byte, fixed read of bit_count bits, ue read, se read, byte align or
// restart. push words carry the raw byte in byte_value; emulation-prevention
// bytes (00 00 03) are dropped on the way into the bit buffer, from the fourth byte on.
// result channel (res_valid/res_stall): exactly one result word per command,
// in order: status, value, byte_removed, removed_total, bits_available.
// throughput: one command per cycle unless results stall; the execute stage peeks the
// bit window, finds leading zeros and advances the read pointer.
// a command passes through the command queue entry, the execute register and
// the value/result register before its result is valid.
// a stalled result holds; the two-entry command queue and the execute register
// keep absorbing commands until they fill, then cmd_stall rises.
// reset clears the queue, read pointer, fill level, raw byte history and
// removal count; buffer contents are not cleared and are never read unwritten.
module exp_golomb_rbsp_reader_core #(
  parameter int BUFFER_BYTES   = 16,
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         mode,
  input  logic [7:0]         byte_value,
  input  logic [5:0]         bit_count,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         status,
  output logic signed [32:0] value,
  output logic               byte_removed,
  output logic [15:0]        removed_total,
  output logic [7:0]         bits_available
);

  logic            q_valid;
  egr_pkg::cmd_t   q_cmd;
  logic            pop;
  logic            a_valid;
  logic            a_take;
  egr_pkg::stage_t a;

  egr_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .mode      (mode),
    .byte_value(byte_value),
    .bit_count (bit_count),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop)
  );

  egr_exec #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_exec (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .cmd    (q_cmd),
    .pop    (pop),
    .a_take (a_take),
    .a_valid(a_valid),
    .a      (a)
  );

  egr_value u_value (
    .clk           (clk),
    .rst           (rst),
    .a_valid       (a_valid),
    .a             (a),
    .a_take        (a_take),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .value         (value),
    .byte_removed  (byte_removed),
    .removed_total (removed_total),
    .bits_available(bits_available)
  );

endmodule
